### hdl/lexdfa_pkg.sv
// types, codes and lookup functions of the lexer automaton
`timescale 1ns / 1ps
`default_nettype none

package lexdfa_pkg;

   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0a;
   localparam logic [7:0] CH_CR      = 8'h0d;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NOT     = 8'h21;
   localparam logic [7:0] CH_AND     = 8'h26;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_TIMES   = 8'h2a;
   localparam logic [7:0] CH_PLUS    = 8'h2b;
   localparam logic [7:0] CH_MINUS   = 8'h2d;
   localparam logic [7:0] CH_DIVIDE  = 8'h2f;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_SEMI    = 8'h3b;
   localparam logic [7:0] CH_LESS    = 8'h3c;
   localparam logic [7:0] CH_EQUAL   = 8'h3d;
   localparam logic [7:0] CH_GREATER = 8'h3e;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5a;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7a;
   localparam logic [7:0] CH_LCURLY  = 8'h7b;
   localparam logic [7:0] CH_OR      = 8'h7c;
   localparam logic [7:0] CH_RCURLY  = 8'h7d;
   localparam logic [7:0] CH_EOF     = 8'hff;

   typedef enum logic [4:0] {
      CL_BAD, CL_DIGIT, CL_LETTER, CL_BLANK, CL_NEWLINE, CL_PLUS, CL_MINUS,
      CL_LESS, CL_GREATER, CL_EQUAL, CL_TIMES, CL_DIVIDE, CL_SEMI, CL_LPAREN,
      CL_RPAREN, CL_LCURLY, CL_RCURLY, CL_NOT, CL_AND, CL_OR, CL_EOF
   } class_type;

   typedef enum logic [4:0] {
      ST_START, ST_DEAD, ST_INT, ST_IDENT, ST_PLUS, ST_PLUSEQ, ST_MINUS,
      ST_LESS, ST_LESSEQ, ST_INSERT, ST_GREATER, ST_GREATEQ, ST_ASSIGN,
      ST_EQUAL, ST_DIVIDE, ST_LINECMT, ST_TIMES, ST_EXPON, ST_BLKCMT,
      ST_CMTEND, ST_SEMI, ST_LPAREN, ST_RPAREN, ST_LCURLY, ST_RCURLY,
      ST_NOT, ST_NOTEQ, ST_EOF, ST_BADTOK, ST_OR, ST_AND
   } state_type;

   typedef enum logic [4:0] {
      TK_BAD, TK_LESS, TK_GREATER, TK_LESSEQ, TK_GREATEQ, TK_EQUAL,
      TK_INSERT, TK_ASSIGN, TK_PLUS, TK_MINUS, TK_PLUSEQ, TK_TIMES,
      TK_DIVIDE, TK_EXPON, TK_SEMI, TK_LPAREN, TK_RPAREN, TK_LCURLY,
      TK_RCURLY, TK_IDENT, TK_INT, TK_EOF, TK_NOTEQ, TK_OR, TK_AND
   } token_type;

   typedef struct packed {
      logic [4:0] token_before;
      logic [4:0] next_state;
      logic       dead_end;
      logic       unknown_byte;
   } result_type;

   function automatic class_type classify(input logic [7:0] c);
      class_type cl;
      case (c) inside
         [CH_DIGIT_0:CH_DIGIT_9]:                 cl = CL_DIGIT;
         [CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]: cl = CL_LETTER;
         CH_SPACE, CH_TAB:                         cl = CL_BLANK;
         CH_CR, CH_LF:                             cl = CL_NEWLINE;
         CH_PLUS:                                  cl = CL_PLUS;
         CH_MINUS:                                 cl = CL_MINUS;
         CH_LESS:                                  cl = CL_LESS;
         CH_GREATER:                               cl = CL_GREATER;
         CH_EQUAL:                                 cl = CL_EQUAL;
         CH_TIMES:                                 cl = CL_TIMES;
         CH_DIVIDE:                                cl = CL_DIVIDE;
         CH_SEMI:                                  cl = CL_SEMI;
         CH_LPAREN:                                cl = CL_LPAREN;
         CH_RPAREN:                                cl = CL_RPAREN;
         CH_LCURLY:                                cl = CL_LCURLY;
         CH_RCURLY:                                cl = CL_RCURLY;
         CH_NOT:                                   cl = CL_NOT;
         CH_AND:                                   cl = CL_AND;
         CH_OR:                                    cl = CL_OR;
         CH_EOF:                                   cl = CL_EOF;
         default:                                  cl = CL_BAD;
      endcase
      return cl;
   endfunction

   function automatic token_type token_of(input state_type st);
      token_type tk;
      case (st)
         ST_INT:      tk = TK_INT;
         ST_IDENT:    tk = TK_IDENT;
         ST_PLUS:     tk = TK_PLUS;
         ST_PLUSEQ:   tk = TK_PLUSEQ;
         ST_MINUS:    tk = TK_MINUS;
         ST_LESS:     tk = TK_LESS;
         ST_LESSEQ:   tk = TK_LESSEQ;
         ST_INSERT:   tk = TK_INSERT;
         ST_GREATER:  tk = TK_GREATER;
         ST_GREATEQ:  tk = TK_GREATEQ;
         ST_ASSIGN:   tk = TK_ASSIGN;
         ST_EQUAL:    tk = TK_EQUAL;
         ST_DIVIDE:   tk = TK_DIVIDE;
         ST_TIMES:    tk = TK_TIMES;
         ST_EXPON:    tk = TK_EXPON;
         ST_SEMI:     tk = TK_SEMI;
         ST_LPAREN:   tk = TK_LPAREN;
         ST_RPAREN:   tk = TK_RPAREN;
         ST_LCURLY:   tk = TK_LCURLY;
         ST_RCURLY:   tk = TK_RCURLY;
         ST_NOTEQ:    tk = TK_NOTEQ;
         ST_EOF:      tk = TK_EOF;
         ST_OR:       tk = TK_OR;
         ST_AND:      tk = TK_AND;
         default:     tk = TK_BAD;
      endcase
      return tk;
   endfunction

   function automatic state_type from_start(input class_type cl);
      state_type nx;
      case (cl)
         CL_BLANK, CL_NEWLINE: nx = ST_START;
         CL_DIGIT:             nx = ST_INT;
         CL_LETTER:            nx = ST_IDENT;
         CL_PLUS:              nx = ST_PLUS;
         CL_MINUS:             nx = ST_MINUS;
         CL_LESS:              nx = ST_LESS;
         CL_GREATER:           nx = ST_GREATER;
         CL_EQUAL:             nx = ST_ASSIGN;
         CL_DIVIDE:            nx = ST_DIVIDE;
         CL_TIMES:             nx = ST_TIMES;
         CL_SEMI:              nx = ST_SEMI;
         CL_LPAREN:            nx = ST_LPAREN;
         CL_RPAREN:            nx = ST_RPAREN;
         CL_LCURLY:            nx = ST_LCURLY;
         CL_RCURLY:            nx = ST_RCURLY;
         CL_NOT:               nx = ST_NOT;
         CL_EOF:               nx = ST_EOF;
         default:              nx = ST_DEAD;
      endcase
      return nx;
   endfunction

   function automatic state_type transition(input state_type st, input class_type cl);
      state_type nx;
      case (st)
         ST_START:   nx = from_start(cl);
         ST_INT:     nx = (cl == CL_DIGIT) ? ST_INT : ST_DEAD;
         ST_IDENT:   nx = (cl == CL_DIGIT || cl == CL_LETTER) ? ST_IDENT : ST_DEAD;
         ST_PLUS:    nx = (cl == CL_EQUAL) ? ST_PLUSEQ : ST_DEAD;
         ST_LESS:    nx = (cl == CL_EQUAL) ? ST_LESSEQ :
                          (cl == CL_LESS) ? ST_INSERT : ST_DEAD;
         ST_GREATER: nx = (cl == CL_EQUAL) ? ST_GREATEQ : ST_DEAD;
         ST_ASSIGN:  nx = (cl == CL_EQUAL) ? ST_EQUAL : ST_DEAD;
         ST_DIVIDE:  nx = (cl == CL_DIVIDE) ? ST_LINECMT :
                          (cl == CL_TIMES) ? ST_BLKCMT : ST_DEAD;
         ST_LINECMT: nx = (cl == CL_NEWLINE) ? ST_START : ST_LINECMT;
         ST_TIMES:   nx = (cl == CL_TIMES) ? ST_EXPON : ST_DEAD;
         ST_BLKCMT:  nx = (cl == CL_TIMES) ? ST_CMTEND : ST_BLKCMT;
         ST_CMTEND:  nx = (cl == CL_DIVIDE) ? ST_START :
                          (cl == CL_TIMES) ? ST_CMTEND : ST_BLKCMT;
         ST_NOT:     nx = (cl == CL_EQUAL) ? ST_NOTEQ : ST_DEAD;
         default:    nx = ST_DEAD;
      endcase
      return nx;
   endfunction

endpackage

`default_nettype wire

### hdl/lexdfa_step.sv
// combinational step of the lexer automaton for one byte
`timescale 1ns / 1ps
`default_nettype none

module lexdfa_step (
   input  wire lexdfa_pkg::state_type  cur_state,
   input  wire logic [7:0]             char_code,
   input  wire logic                   start_new_token,
   output lexdfa_pkg::result_type      result,
   output lexdfa_pkg::state_type       new_state
);

   lexdfa_pkg::state_type base_state;
   lexdfa_pkg::class_type char_class;
   lexdfa_pkg::state_type moved_state;

   always_comb begin
      base_state  = start_new_token ? lexdfa_pkg::ST_START : cur_state;
      char_class  = lexdfa_pkg::classify(char_code);
      moved_state = lexdfa_pkg::transition(base_state, char_class);
      // unknown byte keeps the state
      if (char_class == lexdfa_pkg::CL_BAD) begin
         new_state = base_state;
      end else begin
         new_state = moved_state;
      end
      result.token_before = lexdfa_pkg::token_of(base_state);
      result.next_state   = new_state;
      result.unknown_byte = (char_class == lexdfa_pkg::CL_BAD);
      result.dead_end     = (char_class != lexdfa_pkg::CL_BAD) &&
                            (moved_state == lexdfa_pkg::ST_DEAD);
   end

endmodule

`default_nettype wire

### hdl/lexer_token_dfa_unit.sv
// top level of the table-driven lexer automaton
// Usage:
//   req channel: one source byte per word (req_char_code, 255 = end of file)
//   with req_start_new_token to restart from the start state first.
//   rsp channel: one word per byte: token type of the state before the
//   step, the new state, a dead-end flag and an unknown-byte flag.
//   Path: the accepting edge loads the input register; the word then
//   moves to the result register, which raises rsp_valid, when that is free.
//   Throughput: 1 byte per cycle while rsp_ready holds high; the lexer
//   state register updates as each word moves from the input register to the
//   result register, so class decode plus transition lookup sets the cycle.
//   Reset: the lexer state returns to start and both registers empty.
//   Stall: when rsp_ready is low the result register holds its word, the
//   input register fills, and req_ready drops until rsp_ready returns;
//   no word is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module lexer_token_dfa_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_start_new_token,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [4:0]      rsp_token_before,
   output logic [4:0]      rsp_next_state,
   output logic            rsp_dead_end,
   output logic            rsp_unknown_byte
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [7:0]             in_char_ff;
   logic                   in_start_ff;
   lexdfa_pkg::state_type  state_ff;
   lexdfa_pkg::state_type  state_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   lexdfa_pkg::result_type rsp_word_ff;
   lexdfa_pkg::result_type step_word;
   lexdfa_pkg::state_type  step_state;
   logic                   out_free;
   logic                   advance;
   logic                   req_take;

   lexdfa_step u_step (
      .cur_state       (state_ff),
      .char_code       (in_char_ff),
      .start_new_token (in_start_ff),
      .result          (step_word),
      .new_state       (step_state)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      state_in     = advance ? step_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= lexdfa_pkg::ST_START;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff  <= req_char_code;
         in_start_ff <= req_start_new_token;
      end
      if (advance) begin
         rsp_word_ff <= step_word;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_token_before = rsp_word_ff.token_before;
   assign rsp_next_state   = rsp_word_ff.next_state;
   assign rsp_dead_end     = rsp_word_ff.dead_end;
   assign rsp_unknown_byte = rsp_word_ff.unknown_byte;

   // state register tracks the state of the last word sent out
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (state_ff == lexdfa_pkg::state_type'(rsp_next_state)))
      else $error("lexer state differs from last reported next state");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dead_end) |->
         (rsp_next_state == lexdfa_pkg::ST_DEAD && !rsp_unknown_byte))
      else $error("dead end word without dead state");

   // a held input word moves on when the result register is empty
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !rsp_valid) |=> rsp_valid)
      else $error("input word not moved to result register");

endmodule

`default_nettype wire

### tb/tb.sv
// testbench for lexer_token_dfa_unit: directed byte table, then random token streams
`timescale 1ns / 1ps
`default_nettype none

module tb;

   localparam int N_ITEMS     = 1100;
   localparam int N_DIRECTED  = 25;
   localparam int IDLE_PCT    = 22;
   localparam int PAUSE_AT    = 300;
   localparam int HOLD_AT     = 450;
   localparam int HOLD_CYCLES = 64;
   localparam int CALM_FROM   = 600;
   localparam int CALM_TO     = 800;
   localparam int STALL_LIMIT = 1000;
   localparam int SETTLE      = 8;

   typedef struct packed {
      logic [7:0] code;
      logic       restart;
   } word_type;

   typedef struct packed {
      logic [7:0]             code;
      logic                   restart;
      logic                   typed;
      lexdfa_pkg::result_type want;
   } row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_code = '0;
   logic       req_start_new_token = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [4:0] rsp_token_before;
   logic [4:0] rsp_next_state;
   logic       rsp_dead_end;
   logic       rsp_unknown_byte;

   lexdfa_pkg::state_type  lex_state = lexdfa_pkg::ST_START;
   lexdfa_pkg::result_type due_results[$];
   word_type               stream[$];
   int                     words_sent = 0;
   int                     fail_count = 0;
   int                     quiet_cycles = 0;

   lexdfa_pkg::token_type state_token [0:31] = '{
      lexdfa_pkg::TK_BAD, lexdfa_pkg::TK_BAD, lexdfa_pkg::TK_INT, lexdfa_pkg::TK_IDENT,
      lexdfa_pkg::TK_PLUS, lexdfa_pkg::TK_PLUSEQ, lexdfa_pkg::TK_MINUS, lexdfa_pkg::TK_LESS,
      lexdfa_pkg::TK_LESSEQ, lexdfa_pkg::TK_INSERT, lexdfa_pkg::TK_GREATER,
      lexdfa_pkg::TK_GREATEQ, lexdfa_pkg::TK_ASSIGN, lexdfa_pkg::TK_EQUAL,
      lexdfa_pkg::TK_DIVIDE, lexdfa_pkg::TK_BAD, lexdfa_pkg::TK_TIMES, lexdfa_pkg::TK_EXPON,
      lexdfa_pkg::TK_BAD, lexdfa_pkg::TK_BAD, lexdfa_pkg::TK_SEMI, lexdfa_pkg::TK_LPAREN,
      lexdfa_pkg::TK_RPAREN, lexdfa_pkg::TK_LCURLY, lexdfa_pkg::TK_RCURLY,
      lexdfa_pkg::TK_BAD, lexdfa_pkg::TK_NOTEQ, lexdfa_pkg::TK_EOF, lexdfa_pkg::TK_BAD,
      lexdfa_pkg::TK_OR, lexdfa_pkg::TK_AND, lexdfa_pkg::TK_BAD
   };

   // move out of the start state, by character class
   lexdfa_pkg::state_type start_move [0:20] = '{
      lexdfa_pkg::ST_DEAD, lexdfa_pkg::ST_INT, lexdfa_pkg::ST_IDENT, lexdfa_pkg::ST_START,
      lexdfa_pkg::ST_START, lexdfa_pkg::ST_PLUS, lexdfa_pkg::ST_MINUS, lexdfa_pkg::ST_LESS,
      lexdfa_pkg::ST_GREATER, lexdfa_pkg::ST_ASSIGN, lexdfa_pkg::ST_TIMES,
      lexdfa_pkg::ST_DIVIDE, lexdfa_pkg::ST_SEMI, lexdfa_pkg::ST_LPAREN,
      lexdfa_pkg::ST_RPAREN, lexdfa_pkg::ST_LCURLY, lexdfa_pkg::ST_RCURLY,
      lexdfa_pkg::ST_NOT, lexdfa_pkg::ST_DEAD, lexdfa_pkg::ST_DEAD, lexdfa_pkg::ST_EOF
   };

   logic [7:0] op_chars [0:14] = '{
      lexdfa_pkg::CH_PLUS, lexdfa_pkg::CH_MINUS, lexdfa_pkg::CH_LESS,
      lexdfa_pkg::CH_GREATER, lexdfa_pkg::CH_EQUAL, lexdfa_pkg::CH_TIMES,
      lexdfa_pkg::CH_DIVIDE, lexdfa_pkg::CH_NOT, lexdfa_pkg::CH_SEMI,
      lexdfa_pkg::CH_LPAREN, lexdfa_pkg::CH_RPAREN, lexdfa_pkg::CH_LCURLY,
      lexdfa_pkg::CH_RCURLY, lexdfa_pkg::CH_AND, lexdfa_pkg::CH_OR
   };
   logic [7:0] op_tails [0:2] = '{
      lexdfa_pkg::CH_EQUAL, lexdfa_pkg::CH_LESS, lexdfa_pkg::CH_TIMES
   };
   logic [7:0] ws_chars [0:3] = '{
      lexdfa_pkg::CH_SPACE, lexdfa_pkg::CH_TAB, lexdfa_pkg::CH_LF, lexdfa_pkg::CH_CR
   };

   row_type dir_rows [0:N_DIRECTED-1] = '{
      '{lexdfa_pkg::CH_SPACE,   1'b0, 1'b1,
        '{lexdfa_pkg::TK_BAD, lexdfa_pkg::ST_START, 1'b0, 1'b0}},
      '{8'h00,                  1'b0, 1'b1,
        '{lexdfa_pkg::TK_BAD, lexdfa_pkg::ST_START, 1'b0, 1'b1}},
      '{lexdfa_pkg::CH_LOWER_A, 1'b0, 1'b0, '0},
      '{lexdfa_pkg::CH_DIGIT_9, 1'b0, 1'b0, '0},
      '{lexdfa_pkg::CH_UPPER_Z, 1'b0, 1'b0, '0},
      '{lexdfa_pkg::CH_PLUS,    1'b0, 1'b0, '0},
      '{lexdfa_pkg::CH_DIVIDE,  1'b1, 1'b0, '0},
      '{lexdfa_pkg::CH_TIMES,   1'b0, 1'b0, '0},
      '{lexdfa_pkg::CH_EOF,     1'b0, 1'b0, '0},
      '{lexdfa_pkg::CH_TIMES,   1'b0, 1'b0, '0},
      '{lexdfa_pkg::CH_TIMES,   1'b0, 1'b0, '0},
      '{lexdfa_pkg::CH_DIGIT_0, 1'b0, 1'b0, '0},
      '{lexdfa_pkg::CH_TIMES,   1'b0, 1'b0, '0},
      '{lexdfa_pkg::CH_DIVIDE,  1'b0, 1'b0, '0},
      '{lexdfa_pkg::CH_DIVIDE,  1'b0, 1'b0, '0},
      '{lexdfa_pkg::CH_DIVIDE,  1'b0, 1'b0, '0},
      '{lexdfa_pkg::CH_EOF,     1'b0, 1'b0, '0},
      '{lexdfa_pkg::CH_CR,      1'b0, 1'b0, '0},
      '{lexdfa_pkg::CH_LESS,    1'b0, 1'b0, '0},
      '{lexdfa_pkg::CH_LESS,    1'b0, 1'b0, '0},
      '{8'h80,                  1'b0, 1'b1,
        '{lexdfa_pkg::TK_INSERT, lexdfa_pkg::ST_INSERT, 1'b0, 1'b1}},
      '{lexdfa_pkg::CH_AND,     1'b1, 1'b1,
        '{lexdfa_pkg::TK_BAD, lexdfa_pkg::ST_DEAD, 1'b1, 1'b0}},
      '{lexdfa_pkg::CH_NOT,     1'b1, 1'b0, '0},
      '{lexdfa_pkg::CH_EQUAL,   1'b0, 1'b0, '0},
      '{lexdfa_pkg::CH_EOF,     1'b1, 1'b1,
        '{lexdfa_pkg::TK_BAD, lexdfa_pkg::ST_EOF, 1'b0, 1'b0}}
   };

   lexer_token_dfa_unit uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_char_code       (req_char_code),
      .req_start_new_token (req_start_new_token),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_token_before    (rsp_token_before),
      .rsp_next_state      (rsp_next_state),
      .rsp_dead_end        (rsp_dead_end),
      .rsp_unknown_byte    (rsp_unknown_byte)
   );

   always #2 clock = ~clock;

   function automatic lexdfa_pkg::class_type char_kind(input logic [7:0] c);
      lexdfa_pkg::class_type k;
      k = lexdfa_pkg::CL_BAD;
      if (c >= lexdfa_pkg::CH_DIGIT_0 && c <= lexdfa_pkg::CH_DIGIT_9) begin
         k = lexdfa_pkg::CL_DIGIT;
      end else if ((c >= lexdfa_pkg::CH_UPPER_A && c <= lexdfa_pkg::CH_UPPER_Z) ||
                   (c >= lexdfa_pkg::CH_LOWER_A && c <= lexdfa_pkg::CH_LOWER_Z)) begin
         k = lexdfa_pkg::CL_LETTER;
      end else begin
         case (c)
            lexdfa_pkg::CH_SPACE, lexdfa_pkg::CH_TAB: k = lexdfa_pkg::CL_BLANK;
            lexdfa_pkg::CH_CR, lexdfa_pkg::CH_LF:     k = lexdfa_pkg::CL_NEWLINE;
            lexdfa_pkg::CH_PLUS:                      k = lexdfa_pkg::CL_PLUS;
            lexdfa_pkg::CH_MINUS:                     k = lexdfa_pkg::CL_MINUS;
            lexdfa_pkg::CH_LESS:                      k = lexdfa_pkg::CL_LESS;
            lexdfa_pkg::CH_GREATER:                   k = lexdfa_pkg::CL_GREATER;
            lexdfa_pkg::CH_EQUAL:                     k = lexdfa_pkg::CL_EQUAL;
            lexdfa_pkg::CH_TIMES:                     k = lexdfa_pkg::CL_TIMES;
            lexdfa_pkg::CH_DIVIDE:                    k = lexdfa_pkg::CL_DIVIDE;
            lexdfa_pkg::CH_SEMI:                      k = lexdfa_pkg::CL_SEMI;
            lexdfa_pkg::CH_LPAREN:                    k = lexdfa_pkg::CL_LPAREN;
            lexdfa_pkg::CH_RPAREN:                    k = lexdfa_pkg::CL_RPAREN;
            lexdfa_pkg::CH_LCURLY:                    k = lexdfa_pkg::CL_LCURLY;
            lexdfa_pkg::CH_RCURLY:                    k = lexdfa_pkg::CL_RCURLY;
            lexdfa_pkg::CH_NOT:                       k = lexdfa_pkg::CL_NOT;
            lexdfa_pkg::CH_AND:                       k = lexdfa_pkg::CL_AND;
            lexdfa_pkg::CH_OR:                        k = lexdfa_pkg::CL_OR;
            lexdfa_pkg::CH_EOF:                       k = lexdfa_pkg::CL_EOF;
            default:                                  k = lexdfa_pkg::CL_BAD;
         endcase
      end
      return k;
   endfunction

   function automatic lexdfa_pkg::state_type next_of(input lexdfa_pkg::state_type st,
                                                     input lexdfa_pkg::class_type k);
      lexdfa_pkg::state_type nx;
      nx = lexdfa_pkg::ST_DEAD;
      case (st)
         lexdfa_pkg::ST_START: nx = start_move[k];
         lexdfa_pkg::ST_INT: if (k == lexdfa_pkg::CL_DIGIT) nx = lexdfa_pkg::ST_INT;
         lexdfa_pkg::ST_IDENT: begin
            if (k == lexdfa_pkg::CL_DIGIT || k == lexdfa_pkg::CL_LETTER) begin
               nx = lexdfa_pkg::ST_IDENT;
            end
         end
         lexdfa_pkg::ST_PLUS: if (k == lexdfa_pkg::CL_EQUAL) nx = lexdfa_pkg::ST_PLUSEQ;
         lexdfa_pkg::ST_LESS: begin
            if (k == lexdfa_pkg::CL_EQUAL) nx = lexdfa_pkg::ST_LESSEQ;
            else if (k == lexdfa_pkg::CL_LESS) nx = lexdfa_pkg::ST_INSERT;
         end
         lexdfa_pkg::ST_GREATER: begin
            if (k == lexdfa_pkg::CL_EQUAL) nx = lexdfa_pkg::ST_GREATEQ;
         end
         lexdfa_pkg::ST_ASSIGN: if (k == lexdfa_pkg::CL_EQUAL) nx = lexdfa_pkg::ST_EQUAL;
         lexdfa_pkg::ST_DIVIDE: begin
            if (k == lexdfa_pkg::CL_DIVIDE) nx = lexdfa_pkg::ST_LINECMT;
            else if (k == lexdfa_pkg::CL_TIMES) nx = lexdfa_pkg::ST_BLKCMT;
         end
         lexdfa_pkg::ST_LINECMT: begin
            nx = (k == lexdfa_pkg::CL_NEWLINE) ? lexdfa_pkg::ST_START : lexdfa_pkg::ST_LINECMT;
         end
         lexdfa_pkg::ST_TIMES: if (k == lexdfa_pkg::CL_TIMES) nx = lexdfa_pkg::ST_EXPON;
         lexdfa_pkg::ST_BLKCMT: begin
            nx = (k == lexdfa_pkg::CL_TIMES) ? lexdfa_pkg::ST_CMTEND : lexdfa_pkg::ST_BLKCMT;
         end
         lexdfa_pkg::ST_CMTEND: begin
            if (k == lexdfa_pkg::CL_DIVIDE) nx = lexdfa_pkg::ST_START;
            else if (k == lexdfa_pkg::CL_TIMES) nx = lexdfa_pkg::ST_CMTEND;
            else nx = lexdfa_pkg::ST_BLKCMT;
         end
         lexdfa_pkg::ST_NOT: if (k == lexdfa_pkg::CL_EQUAL) nx = lexdfa_pkg::ST_NOTEQ;
         default: nx = lexdfa_pkg::ST_DEAD;
      endcase
      return nx;
   endfunction

   // one lexer step on the local state; unknown bytes leave the state alone
   function automatic lexdfa_pkg::result_type lex_step(input logic [7:0] c,
                                                       input logic restart);
      lexdfa_pkg::result_type r;
      lexdfa_pkg::class_type  k;
      if (restart) lex_state = lexdfa_pkg::ST_START;
      k = char_kind(c);
      r.token_before = state_token[lex_state];
      r.unknown_byte = (k == lexdfa_pkg::CL_BAD);
      if (k != lexdfa_pkg::CL_BAD) lex_state = next_of(lex_state, k);
      r.next_state = lex_state;
      r.dead_end = (lex_state == lexdfa_pkg::ST_DEAD) && (k != lexdfa_pkg::CL_BAD);
      return r;
   endfunction

   function automatic bit calm_span();
      return words_sent >= CALM_FROM && words_sent < CALM_TO;
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'($urandom_range(lexdfa_pkg::CH_DIGIT_9, lexdfa_pkg::CH_DIGIT_0));
   endfunction

   function automatic logic [7:0] rand_letter();
      if ($urandom_range(1)) begin
         return 8'($urandom_range(lexdfa_pkg::CH_LOWER_Z, lexdfa_pkg::CH_LOWER_A));
      end
      return 8'($urandom_range(lexdfa_pkg::CH_UPPER_Z, lexdfa_pkg::CH_UPPER_A));
   endfunction

   task automatic put(input logic [7:0] c, input logic s);
      word_type w;
      w.code = c;
      w.restart = s;
      stream.push_back(w);
   endtask

   // one lexeme, mostly well formed, sometimes noise or a broken tail
   task automatic add_lexeme();
      logic       lead;
      logic [7:0] c;
      lead = ($urandom_range(9) < 7);
      case ($urandom_range(9))
         0: begin
            put(rand_letter(), lead);
            repeat ($urandom_range(6)) begin
               if ($urandom_range(1)) put(rand_letter(), 1'b0);
               else put(rand_digit(), 1'b0);
            end
         end
         1: begin
            put(rand_digit(), lead);
            repeat ($urandom_range(5)) put(rand_digit(), 1'b0);
         end
         2, 3: begin
            put(op_chars[4'($urandom_range(14))], lead);
            if ($urandom_range(1)) put(op_tails[2'($urandom_range(2))], 1'b0);
         end
         4: begin
            put(lexdfa_pkg::CH_DIVIDE, lead);
            put(lexdfa_pkg::CH_DIVIDE, 1'b0);
            repeat ($urandom_range(8)) begin
               c = 8'($urandom_range(255));
               if (char_kind(c) == lexdfa_pkg::CL_NEWLINE) c = lexdfa_pkg::CH_SPACE;
               put(c, 1'b0);
            end
            put($urandom_range(1) ? lexdfa_pkg::CH_LF : lexdfa_pkg::CH_CR, 1'b0);
         end
         5: begin
            put(lexdfa_pkg::CH_DIVIDE, lead);
            put(lexdfa_pkg::CH_TIMES, 1'b0);
            repeat ($urandom_range(10)) begin
               if ($urandom_range(2) == 0) put(lexdfa_pkg::CH_TIMES, 1'b0);
               else put(8'($urandom_range(255)), 1'b0);
            end
            put(lexdfa_pkg::CH_TIMES, 1'b0);
            put(lexdfa_pkg::CH_DIVIDE, 1'b0);
         end
         6: begin
            put(ws_chars[2'($urandom_range(3))], lead);
            repeat ($urandom_range(3)) put(ws_chars[2'($urandom_range(3))], 1'b0);
         end
         7: put(lexdfa_pkg::CH_EOF, lead);
         default: begin
            repeat (1 + $urandom_range(2)) put(8'($urandom_range(255)), 1'($urandom_range(1)));
         end
      endcase
      if ($urandom_range(9) == 0) put(8'($urandom_range(255)), 1'b0);
   endtask

   task automatic send_word(input word_type w);
      while (!calm_span() && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= w.code;
      req_start_new_token <= w.restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      word_type               w;
      lexdfa_pkg::result_type r;
      while (stream.size() < N_ITEMS - N_DIRECTED) add_lexeme();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < N_DIRECTED; i++) begin
         w.code = dir_rows[5'(i)].code;
         w.restart = dir_rows[5'(i)].restart;
         send_word(w);
         r = lex_step(w.code, w.restart);
         due_results.push_back(dir_rows[5'(i)].typed ? dir_rows[5'(i)].want : r);
      end
      while (stream.size() != 0) begin
         if (words_sent == PAUSE_AT) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (due_results.size() != 0) @(posedge clock);
         end
         w = stream.pop_front();
         send_word(w);
         due_results.push_back(lex_step(w.code, w.restart));
      end
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   // result side: random back-pressure, one long hold-off
   initial begin
      bit held;
      held = 1'b0;
      @(posedge clock);
      forever begin
         if (!held && words_sent >= HOLD_AT) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= calm_span() || ($urandom_range(99) >= IDLE_PCT);
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      lexdfa_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            $display("%0t unexpected word: token %0d state %0d dead %0d unknown %0d", $time,
                     rsp_token_before, rsp_next_state, rsp_dead_end, rsp_unknown_byte);
            fail_count++;
         end else begin
            want = due_results.pop_front();
            check_field("token_before", want.token_before, rsp_token_before);
            check_field("next_state", want.next_state, rsp_next_state);
            check_field("dead_end", want.dead_end, rsp_dead_end);
            check_field("unknown_byte", want.unknown_byte, rsp_unknown_byte);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

`default_nettype wire

### sim.f
hdl/lexdfa_pkg.sv
hdl/lexdfa_step.sv
hdl/lexer_token_dfa_unit.sv
tb/tb.sv
